>>> rtl/core/fbc_pkg.sv
// ---------------------------------------------------------------------------
// fbc_pkg: shared types and constants for the frustum box culling block
// Beat layouts, plane construction tables and arithmetic widths.
// ---------------------------------------------------------------------------
package fbc_pkg;

  localparam int COORD_W = 32;
  localparam int COEF_W  = 33;
  localparam int PROD_W  = COEF_W + COORD_W;
  localparam int DIST_W  = PROD_W + 3;
  localparam int MAX_PLANES = 6;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_code_t;

  typedef struct packed {
    logic                      command;
    logic [3:0]                entry_index;
    logic signed [COORD_W-1:0] entry_value;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
  } cmd_beat_t;

  typedef struct packed {
    logic visible;
    logic straddles;
  } result_beat_t;

  // Row combined with row 3 for each plane: top, bottom, left, right, near, far.
  localparam logic [1:0] PLANE_ROW [MAX_PLANES] = '{2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2};
  // One where the row is added, zero where it is subtracted.
  localparam logic PLANE_ADD [MAX_PLANES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

endpackage

>>> rtl/core/fbc_if.sv
// ---------------------------------------------------------------------------
// fbc_if: valid/ready channels of the frustum box culling block
// One interface for command beats and one for result beats.
// ---------------------------------------------------------------------------
interface fbc_cmd_if import fbc_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fbc_res_if import fbc_pkg::*; ();
  logic         valid;
  logic         ready;
  result_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/frustum_box_culling_top.sv
// ---------------------------------------------------------------------------
// frustum_box_culling_top: AABB test against planes taken from a 4x4 matrix
// A box beat passes the corner and coefficient, product and sign stages, then the result register.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds as one when the final result register is full and not taken.
// Load beats write the matrix at acceptance and give no result.
// Reset (synchronous) clears the matrix to zero and all stage valid bits.
// ---------------------------------------------------------------------------
module frustum_box_culling_top import fbc_pkg::*; #(
  parameter int PLANE_COUNT = 6
) (
  input  logic      clk,
  input  logic      rst,
  fbc_cmd_if.sink   cmd,
  fbc_res_if.source result
);

  logic signed [COORD_W-1:0] matrix [16];
  logic advance;
  logic v1, v2, v3, v4;

  // Coordinates of the box in flight through stages one and two.
  logic signed [COORD_W-1:0] bmin1 [3];
  logic signed [COORD_W-1:0] bmax1 [3];

  logic far_neg3  [PLANE_COUNT];
  logic near_neg3 [PLANE_COUNT];
  result_beat_t res4;

  // The pipeline moves whenever the output register is free or drained.
  assign advance   = !v4 || result.ready;
  assign cmd.ready = advance;

  // Matrix loads take effect at acceptance, so later boxes see them.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) matrix[i] <= '0;
    end else if (cmd.valid && advance && cmd.data.command == CMD_LOAD) begin
      matrix[cmd.data.entry_index] <= cmd.data.entry_value;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= cmd.valid && cmd.data.command == CMD_TEST;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage one holds the box corners.
  always_ff @(posedge clk) begin
    if (advance) begin
      bmin1[0] <= cmd.data.box_min_x;
      bmin1[1] <= cmd.data.box_min_y;
      bmin1[2] <= cmd.data.box_min_z;
      bmax1[0] <= cmd.data.box_max_x;
      bmax1[1] <= cmd.data.box_max_y;
      bmax1[2] <= cmd.data.box_max_z;
    end
  end

  // One lane per plane: coefficients, products, then the distance signs.
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    logic signed [COEF_W-1:0] coef_next [4];
    logic signed [COEF_W-1:0] coef1 [4];
    logic signed [PROD_W-1:0] far_prod2  [3];
    logic signed [PROD_W-1:0] near_prod2 [3];
    logic signed [DIST_W-1:0] d2;
    logic signed [DIST_W-1:0] far_sum;
    logic signed [DIST_W-1:0] near_sum;

    // Row 3 plus or minus the selected row, per matrix column.
    always_comb begin
      for (int k = 0; k < 4; k++) begin
        if (PLANE_ADD[p]) begin
          coef_next[k] = COEF_W'(matrix[4*k+3]) + COEF_W'(matrix[4*k+PLANE_ROW[p]]);
        end else begin
          coef_next[k] = COEF_W'(matrix[4*k+3]) - COEF_W'(matrix[4*k+PLANE_ROW[p]]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (advance) coef1 <= coef_next;
    end

    // Pick far and near corners by coefficient sign, then multiply.
    always_ff @(posedge clk) begin
      if (advance) begin
        for (int k = 0; k < 3; k++) begin
          if (!coef1[k][COEF_W-1] && coef1[k] != '0) begin
            far_prod2[k]  <= coef1[k] * bmax1[k];
            near_prod2[k] <= coef1[k] * bmin1[k];
          end else begin
            far_prod2[k]  <= coef1[k] * bmin1[k];
            near_prod2[k] <= coef1[k] * bmax1[k];
          end
        end
        d2 <= DIST_W'(coef1[3]) <<< 16;
      end
    end

    // Exact distance sums; only the sign is kept.
    assign far_sum  = DIST_W'(far_prod2[0]) + DIST_W'(far_prod2[1])
                    + DIST_W'(far_prod2[2]) + d2;
    assign near_sum = DIST_W'(near_prod2[0]) + DIST_W'(near_prod2[1])
                    + DIST_W'(near_prod2[2]) + d2;

    always_ff @(posedge clk) begin
      if (advance) begin
        far_neg3[p]  <= far_sum[DIST_W-1];
        near_neg3[p] <= near_sum[DIST_W-1];
      end
    end
  end

  // Combine the planes into the result beat.
  always_comb begin
    logic any_far;
    logic any_near;
    any_far  = 1'b0;
    any_near = 1'b0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      any_far  = any_far  | far_neg3[p];
      any_near = any_near | near_neg3[p];
    end
    res4.visible   = !any_far;
    res4.straddles = !any_far && any_near;
  end

  always_ff @(posedge clk) begin
    if (advance) result.data <= res4;
  end

  assign result.valid = v4;

endmodule
